/* src/rbps_pkg.sv */
package rbps_pkg;

  // Field widths of the block's ports.
  localparam int unsigned PriceW    = 32;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned BrickW    = 24;
  localparam int unsigned RiskW     = 14;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = BrickW;
  localparam int unsigned LotW      = 26;
  localparam int unsigned StopW     = 25;
  localparam int unsigned TargetW   = 26;

  // Longest run of bricks that one tick may form.
  localparam int unsigned MaxBricks = 64;
  localparam int unsigned CntW      = $clog2(MaxBricks + 2);

  // The lot is floor(LotScale * risk / brick), clamped to [1, LotMax].
  localparam int unsigned DividendW = 27;
  localparam int unsigned DivCntW   = $clog2(DividendW);
  localparam logic [12:0]     LotScale = 13'd5000;
  localparam logic [LotW-1:0] LotMax   = LotW'(50000000);

  // Shared add/subtract unit: wide enough for a price or a division trial.
  localparam int unsigned OpW  = (PriceW > BrickW + 1) ? PriceW : BrickW + 1;
  localparam int unsigned AluW = OpW + 1;

  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    KindNone     = 2'd0,
    KindSetupOne = 2'd1,
    KindSetupTwo = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBrickSize = CfgIdxW'(0),
    CfgSetupOne  = CfgIdxW'(1),
    CfgSetupTwo  = CfgIdxW'(2),
    CfgRisk      = CfgIdxW'(3)
  } cfg_idx_e;

  typedef enum logic [6:0] {
    StIdle     = 7'b0000001,
    StAnchor   = 7'b0000010,
    StDiffUp   = 7'b0000100,
    StDiffDown = 7'b0001000,
    StCount    = 7'b0010000,
    StDivide   = 7'b0100000,
    StEmit     = 7'b1000000
  } state_e;

  // Request to the pattern checker: the two most recent directions, the
  // direction of the brick being formed, the enables and the lot inputs.
  typedef struct packed {
    dir_e                 old_dir;
    dir_e                 mid_dir;
    dir_e                 new_dir;
    logic                 en_one;
    logic                 en_two;
    logic [BrickW-1:0]    brick;
    logic [DividendW-1:0] quot;
  } sig_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [LotW-1:0]    lot;
    logic [StopW-1:0]   stop;
    logic [TargetW-1:0] target;
  } sig_rsp_t;

endpackage

/* src/rbps_sig.sv */
module rbps_sig (
  input  rbps_pkg::sig_req_t req_i,
  output rbps_pkg::sig_rsp_t rsp_o
);
  import rbps_pkg::*;

  kind_e           kind;
  logic [LotW-1:0] lot;

  // Setup one wins over setup two when both could match.
  always_comb begin
    if (req_i.en_one && req_i.old_dir == DirDown && req_i.mid_dir == DirDown &&
        req_i.new_dir == DirUp) begin
      kind = KindSetupOne;
    end else if (req_i.en_two && req_i.old_dir == DirUp && req_i.mid_dir == DirUp &&
                 req_i.new_dir == DirUp) begin
      kind = KindSetupTwo;
    end else begin
      kind = KindNone;
    end
  end

  always_comb begin
    if (req_i.quot == '0) begin
      lot = LotW'(1);
    end else if (req_i.quot > DividendW'(LotMax)) begin
      lot = LotMax;
    end else begin
      lot = req_i.quot[LotW-1:0];
    end
  end

  always_comb begin
    rsp_o.kind   = kind;
    rsp_o.lot    = '0;
    rsp_o.stop   = '0;
    rsp_o.target = '0;
    if (kind != KindNone) begin
      rsp_o.lot    = lot;
      rsp_o.stop   = StopW'({req_i.brick, 1'b0});
      rsp_o.target = TargetW'({req_i.brick, 1'b0}) + TargetW'(req_i.brick);
    end
  end

endmodule

/* src/renko_brick_pattern_signaller.sv */
// Renko brick former with a buy-pattern signaller. Each price tick word
// (price and timestamp, prices in hundredths) forms zero or more brick
// words on the output channel. The first tick after reset forms one neutral
// anchor brick at the tick price. Every later tick forms one brick per whole
// brick_size of movement from the last close, all in the same direction, at
// most 64 per tick; a longer run is cut at 64 and every brick of it carries
// run_saturated. A brick whose last three directions read red, red, green
// (setup one, which wins) or green, green, green (setup two) carries a buy
// signal with lot size, stop and target; otherwise those fields are zero.
// The block works on one tick at a time and drops in_ready_o while busy.
// A later tick first forms the price difference, upward and, if the price
// did not rise, downward, then runs the counting loop, which repeatedly
// subtracts the brick size from the difference on the single shared
// add/subtract unit; a tick that moves less than one brick ends there. A
// tick that forms bricks then runs a restoring division for the lot size on
// the same unit, and finally forms one brick per cycle while the output
// register is free. A finished brick waits in the output register, so a
// new tick word is taken as soon as the sequencer is idle. Configuration
// writes are always accepted and must only be issued while the block is
// idle.
module renko_brick_pattern_signaller (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rbps_pkg::CfgDataW-1:0]   cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbps_pkg::PriceW-1:0]     price_i,
  input  logic [rbps_pkg::TimeW-1:0]      tick_time_i,

  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rbps_pkg::PriceW-1:0]     brick_open_o,
  output logic [rbps_pkg::PriceW-1:0]     brick_close_o,
  output logic [1:0]                      brick_dir_o,
  output logic [rbps_pkg::TimeW-1:0]      brick_time_o,
  output logic [1:0]                      signal_kind_o,
  output logic [rbps_pkg::LotW-1:0]       lot_hundredths_o,
  output logic [rbps_pkg::StopW-1:0]      stop_distance_o,
  output logic [rbps_pkg::TargetW-1:0]    target_distance_o,
  output logic                            last_of_run_o,
  output logic                            run_saturated_o
);
  import rbps_pkg::*;

  localparam logic [CntW-1:0] CntStop = CntW'(MaxBricks + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxBricks);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DividendW - 1);

  // Configuration registers.
  logic [BrickW-1:0] brick_size_q;
  logic              en_one_q;
  logic              en_two_q;
  logic [RiskW-1:0]  risk_q;

  // Architectural state.
  logic              anchor_q;
  logic [PriceW-1:0] last_close_q;
  dir_e              dirs_q [3];

  // Per-tick working registers.
  state_e               state_q, state_d;
  logic [PriceW-1:0]    price_q;
  logic [TimeW-1:0]     time_q;
  logic [PriceW-1:0]    diff_q;
  dir_e                 dir_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      n_q;
  logic                 sat_q;
  logic [CntW-1:0]      emit_cnt_q;
  logic [BrickW-1:0]    rem_q;
  logic [DividendW-1:0] quot_q;
  logic [DivCntW-1:0]   div_cnt_q;

  // Output register.
  logic                 out_valid_q;
  logic [PriceW-1:0]    open_q;
  logic [PriceW-1:0]    close_q;
  dir_e                 out_dir_q;
  logic [TimeW-1:0]     out_time_q;
  sig_rsp_t             out_sig_q;
  logic                 last_q;
  logic                 out_sat_q;

  logic [BrickW-1:0] brick_eff;
  logic [BrickW:0]   trial;
  logic [OpW-1:0]    alu_a;
  logic [OpW-1:0]    alu_b;
  logic              alu_sub;
  logic [AluW-1:0]   alu_res;
  logic              borrow;
  logic              slot_free;
  logic              load_out;
  logic              count_more;
  logic              emit_last;
  sig_req_t          sig_req;
  sig_rsp_t          sig_rsp;

  // A brick size of zero behaves as one.
  assign brick_eff = (brick_size_q == '0) ? BrickW'(1) : brick_size_q;

  // Next trial of the restoring division: remainder shifted left by one,
  // with the next dividend bit brought in from the top of the quotient word.
  assign trial = {rem_q, quot_q[DividendW-1]};

  // The one add/subtract unit, steered by the sequencer state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      StDiffUp: begin
        alu_a = OpW'(price_q);
        alu_b = OpW'(last_close_q);
      end
      StDiffDown: begin
        alu_a = OpW'(last_close_q);
        alu_b = OpW'(price_q);
      end
      StCount: begin
        alu_a = OpW'(diff_q);
        alu_b = OpW'(brick_eff);
      end
      StDivide: begin
        alu_a = OpW'(trial);
        alu_b = OpW'(brick_eff);
      end
      StEmit: begin
        alu_a   = OpW'(last_close_q);
        alu_b   = OpW'(brick_eff);
        alu_sub = (dir_q == DirDown);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[AluW-1];

  assign slot_free  = !out_valid_q || out_ready_i;
  assign load_out   = slot_free && (state_q == StAnchor || state_q == StEmit);
  assign count_more = !borrow && (cnt_q != CntStop);
  assign emit_last  = (CntW'(emit_cnt_q + 1'b1) == n_q);

  // Pattern check on the brick being formed this cycle.
  assign sig_req.old_dir = dirs_q[1];
  assign sig_req.mid_dir = dirs_q[2];
  assign sig_req.new_dir = dir_q;
  assign sig_req.en_one  = en_one_q;
  assign sig_req.en_two  = en_two_q;
  assign sig_req.brick   = brick_eff;
  assign sig_req.quot    = quot_q;

  rbps_sig u_sig (
    .req_i (sig_req),
    .rsp_o (sig_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = anchor_q ? StDiffUp : StAnchor;
        end
      end
      StAnchor: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      StDiffUp: begin
        if (!borrow && alu_res[PriceW-1:0] != '0) begin
          state_d = StCount;
        end else begin
          state_d = StDiffDown;
        end
      end
      StDiffDown: begin
        state_d = StCount;
      end
      StCount: begin
        if (!count_more) begin
          state_d = (cnt_q == '0) ? StIdle : StDivide;
        end
      end
      StDivide: begin
        if (div_cnt_q == DivLast) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free && emit_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      brick_size_q <= BrickW'(1000);
      en_one_q     <= 1'b1;
      en_two_q     <= 1'b1;
      risk_q       <= RiskW'(200);
      anchor_q     <= 1'b0;
      last_close_q <= '0;
      dirs_q[0]    <= DirNone;
      dirs_q[1]    <= DirNone;
      dirs_q[2]    <= DirNone;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      emit_cnt_q   <= '0;
      div_cnt_q    <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgBrickSize: brick_size_q <= cfg_data_i[BrickW-1:0];
          CfgSetupOne:  en_one_q     <= cfg_data_i[0];
          CfgSetupTwo:  en_two_q     <= cfg_data_i[0];
          CfgRisk:      risk_q       <= cfg_data_i[RiskW-1:0];
          default: begin
          end
        endcase
      end

      // A new brick word replaces the one leaving in the same cycle.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          cnt_q <= '0;
        end
        StAnchor: begin
          if (slot_free) begin
            anchor_q     <= 1'b1;
            last_close_q <= price_q;
            dirs_q[0]    <= dirs_q[1];
            dirs_q[1]    <= dirs_q[2];
            dirs_q[2]    <= DirNone;
          end
        end
        StCount: begin
          if (count_more) begin
            cnt_q <= CntW'(cnt_q + 1'b1);
          end else begin
            div_cnt_q <= '0;
          end
        end
        StDivide: begin
          div_cnt_q <= DivCntW'(div_cnt_q + 1'b1);
          if (div_cnt_q == DivLast) begin
            emit_cnt_q <= '0;
          end
        end
        StEmit: begin
          if (slot_free) begin
            last_close_q <= alu_res[PriceW-1:0];
            dirs_q[0]    <= dirs_q[1];
            dirs_q[1]    <= dirs_q[2];
            dirs_q[2]    <= dir_q;
            emit_cnt_q   <= CntW'(emit_cnt_q + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          price_q <= price_i;
          time_q  <= tick_time_i;
        end
      end
      StAnchor: begin
        if (slot_free) begin
          open_q     <= price_q;
          close_q    <= price_q;
          out_dir_q  <= DirNone;
          out_time_q <= time_q;
          out_sig_q  <= '0;
          last_q     <= 1'b1;
          out_sat_q  <= 1'b0;
        end
      end
      StDiffUp: begin
        dir_q  <= DirUp;
        diff_q <= alu_res[PriceW-1:0];
      end
      StDiffDown: begin
        dir_q  <= DirDown;
        diff_q <= alu_res[PriceW-1:0];
      end
      StCount: begin
        if (count_more) begin
          diff_q <= alu_res[PriceW-1:0];
        end else begin
          sat_q  <= (cnt_q > CntMax);
          n_q    <= (cnt_q > CntMax) ? CntMax : cnt_q;
          rem_q  <= '0;
          quot_q <= DividendW'(LotScale) * DividendW'(risk_q);
        end
      end
      StDivide: begin
        rem_q  <= borrow ? trial[BrickW-1:0] : alu_res[BrickW-1:0];
        quot_q <= {quot_q[DividendW-2:0], !borrow};
      end
      StEmit: begin
        if (slot_free) begin
          open_q     <= last_close_q;
          close_q    <= alu_res[PriceW-1:0];
          out_dir_q  <= dir_q;
          out_time_q <= time_q;
          out_sig_q  <= sig_rsp;
          last_q     <= emit_last;
          out_sat_q  <= sat_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign brick_open_o      = open_q;
  assign brick_close_o     = close_q;
  assign brick_dir_o       = out_dir_q;
  assign brick_time_o      = out_time_q;
  assign signal_kind_o     = out_sig_q.kind;
  assign lot_hundredths_o  = out_sig_q.lot;
  assign stop_distance_o   = out_sig_q.stop;
  assign target_distance_o = out_sig_q.target;
  assign last_of_run_o     = last_q;
  assign run_saturated_o   = out_sat_q;

  // A tick word keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("sequencer ready right after taking a tick word");

  // A directional brick always moves the price by a nonzero brick size.
  a_brick_moves: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brick_dir_o != DirNone |-> brick_open_o != brick_close_o
  ) else $error("directional brick with equal open and close");

  // The emit loop never runs past the run length, which never exceeds the limit.
  a_emit_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> emit_cnt_q < n_q && n_q <= CntMax
  ) else $error("brick count beyond run length");

  // Signal fields are zero on bricks without a buy signal.
  a_quiet_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_kind_o == KindNone |->
      lot_hundredths_o == '0 && stop_distance_o == '0 && target_distance_o == '0
  ) else $error("signal fields set on a brick without signal");

endmodule
